// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the RTL; tqbp_back includes them.
// Build with ASSERT_OFF defined to drop all checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Checked on every rising edge outside of reset.
`define TQBP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define TQBP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define TQBP_ASSERT(lbl, clk, rstn, prop, msg)
`define TQBP_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== rtl/core/tqbp_pkg.sv =====
package tqbp_pkg;

  localparam int unsigned CompW        = 8;
  localparam int unsigned ColorDepthW  = 4;
  localparam int unsigned AlphaDepthW  = 3;
  localparam int unsigned WordW        = 31;  // 7 alpha bits + 3 x 8 color bits
  localparam int unsigned LenW         = 5;
  localparam int unsigned AccW         = 38;  // 7 leftover bits + one full pixel word
  localparam int unsigned CntW         = 6;
  localparam int unsigned FifoDepthDef = 2;
  localparam int unsigned CfgIdxW      = 2;
  localparam int unsigned CfgDataW     = 4;

  localparam logic [ColorDepthW-1:0] ColorDepthMax = 4'd8;
  localparam logic [ColorDepthW-1:0] ColorDepthMin = 4'd1;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgColorDepth = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgAlphaDepth = 2'd1;

  typedef struct packed {
    logic [CompW-1:0] red;
    logic [CompW-1:0] green;
    logic [CompW-1:0] blue;
    logic [CompW-1:0] alpha;
    logic             final_pixel;
  } pixel_t;

  typedef struct packed {
    logic [CompW-1:0] packed_byte;
    logic             run_end;
    logic             stream_end;
  } byte_t;

  typedef struct packed {
    logic [ColorDepthW-1:0] color_depth;
    logic [AlphaDepthW-1:0] alpha_depth;
  } cfg_t;

  // one pixel's worth of stream bits, right aligned
  typedef struct packed {
    logic [WordW-1:0] bits;
    logic [LenW-1:0]  len;
    logic             fin;
  } word_t;

  // Rounded depth reduction (v*(2^d-1)+127)/255.
  // x stays below 2^16, where (x + (x>>8) + 1) >> 8 equals x/255.
  function automatic logic [CompW-1:0] reduce_depth(input logic [CompW-1:0] v,
                                                    input logic [ColorDepthW-1:0] d);
    logic [6:0]  top;
    logic [15:0] x;
    logic [15:0] q;
    top = 7'((8'd1 << d[2:0]) - 8'd1);
    x   = 16'(v) * 16'(top) + 16'd127;
    q   = (x + (x >> 8) + 16'd1) >> 8;
    if (d >= ColorDepthMax) begin
      return v;
    end
    return q[CompW-1:0];
  endfunction

endpackage

// ===== rtl/core/tqbp_front.sv =====
module tqbp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tqbp_pkg::pixel_t  in_data_i,
  input  tqbp_pkg::cfg_t    cfg_i,
  output logic              word_valid_o,
  input  logic              word_ready_i,
  output tqbp_pkg::word_t   word_o
);
  import tqbp_pkg::*;

  logic [ColorDepthW-1:0] cd;
  logic [ColorDepthW-1:0] ad;
  logic                   valid_q, valid_d;
  logic [CompW-1:0]       red_q, green_q, blue_q, alpha_q;
  logic                   fin_q;
  logic                   accept;
  logic [WordW-1:0]       w;

  // clamp color depth to 1..8
  always_comb begin
    cd = cfg_i.color_depth;
    if (cd < ColorDepthMin) begin
      cd = ColorDepthMin;
    end else if (cd > ColorDepthMax) begin
      cd = ColorDepthMax;
    end
  end

  assign ad = ColorDepthW'(cfg_i.alpha_depth);

  assign in_ready_o = !valid_q || word_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // stage holding the reduced components
  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (word_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // depth 0 for alpha reduces to zero, so no field is added
  always_ff @(posedge clk_i) begin
    if (accept) begin
      red_q   <= reduce_depth(in_data_i.red, cd);
      green_q <= reduce_depth(in_data_i.green, cd);
      blue_q  <= reduce_depth(in_data_i.blue, cd);
      alpha_q <= reduce_depth(in_data_i.alpha, ad);
      fin_q   <= in_data_i.final_pixel;
    end
  end

  // concatenate alpha, red, green, blue into one right-aligned word
  always_comb begin
    w = WordW'(alpha_q);
    w = (w << cd) | WordW'(red_q);
    w = (w << cd) | WordW'(green_q);
    w = (w << cd) | WordW'(blue_q);
  end

  assign word_valid_o = valid_q;
  assign word_o.bits  = w;
  assign word_o.len   = LenW'(ad) + LenW'(cd) + LenW'(cd) + LenW'(cd);
  assign word_o.fin   = fin_q;

endmodule

// ===== rtl/core/tqbp_fifo.sv =====
module tqbp_fifo #(
  parameter int unsigned DEPTH = tqbp_pkg::FifoDepthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  tqbp_pkg::word_t  push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output tqbp_pkg::word_t  pop_data_o
);
  import tqbp_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntFW = $clog2(DEPTH + 1);

  word_t            mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntFW-1:0] count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != CntFW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CntFW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CntFW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/core/tqbp_back.sv =====
`include "assert_macros.svh"

module tqbp_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             word_valid_i,
  output logic             word_ready_o,
  input  tqbp_pkg::word_t  word_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output tqbp_pkg::byte_t  out_data_o
);
  import tqbp_pkg::*;

  localparam logic [CntW-1:0] ByteBits = CntW'(8);

  logic [AccW-1:0] acc_q, acc_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            fin_q, fin_d;
  logic            out_valid_q, out_valid_d;
  byte_t           out_q, out_d;

  logic [CntW-1:0]  rem;
  logic [AccW-1:0]  shifted;
  logic [CompW-1:0] flush_byte;
  logic             has_byte, flush, slot_free, emit;
  logic [CntW-1:0]  cnt_e;
  logic             fin_e, busy_e, run_end, pop;

  // what the current pixel still owes
  assign rem        = cnt_q - ByteBits;
  assign has_byte   = (cnt_q >= ByteBits);
  assign flush      = !has_byte && fin_q && (cnt_q != '0);
  assign slot_free  = !out_valid_q || out_ready_i;
  assign emit       = (has_byte || flush) && slot_free;
  assign shifted    = acc_q >> rem;
  assign flush_byte = acc_q[CompW-1:0] << (4'd8 - 4'(cnt_q));

  // last byte of a pixel: a flush, or fewer than 8 bits left and no flush to follow
  assign run_end = flush || ((rem < ByteBits) && !(fin_q && (rem != '0)));

  // state once this cycle's byte is gone
  always_comb begin
    cnt_e = cnt_q;
    fin_e = fin_q;
    if (emit) begin
      cnt_e = has_byte ? rem : '0;
      fin_e = fin_q && !run_end;
    end
  end

  assign busy_e       = (cnt_e >= ByteBits) || (fin_e && (cnt_e != '0));
  assign word_ready_o = !busy_e;
  assign pop          = word_valid_i && !busy_e;

  // append the next pixel word behind the leftover bits
  always_comb begin
    acc_d = acc_q;
    cnt_d = cnt_e;
    fin_d = fin_e;
    if (pop) begin
      acc_d = (acc_q << word_i.len) | AccW'(word_i.bits);
      cnt_d = cnt_e + CntW'(word_i.len);
      fin_d = word_i.fin;
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (emit) begin
      out_valid_d      = 1'b1;
      out_d.packed_byte = has_byte ? shifted[CompW-1:0] : flush_byte;
      out_d.run_end    = run_end;
      out_d.stream_end = run_end && fin_q;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      fin_q       <= fin_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `TQBP_ASSERT(a_cnt_fits, clk_i, rst_ni, cnt_q <= CntW'(AccW), "bit count beyond accumulator")
  `TQBP_ASSERT(a_fin_has_bits, clk_i, rst_ni, !(fin_q && (cnt_q == '0)), "final pixel with no bits")
  `TQBP_ASSERT(a_stream_end_run_end, clk_i, rst_ni, (out_valid_q && out_q.stream_end) |-> out_q.run_end, "stream end without run end")

endmodule

// ===== rtl/core/texel_quantize_bit_packer_core.sv =====
// Texel quantizer and MSB-first bit packer.
// Input channel (in_valid_i/in_ready_o, in_data_i): one RGBA8 pixel per item,
// with final_pixel marking the last pixel of an image. Components are rounded
// to the configured depths and appended as alpha (if its depth is nonzero),
// red, green, blue to a bit stream.
// Output channel (out_valid_o/out_ready_i, out_data_o): one stream byte per
// item; run_end tags the last byte a pixel completes, stream_end the final
// byte of the image, zero padded where its bits do not fill it.
// Config: cfg_we_i writes cfg_wdata_i to register cfg_idx_i (0 color depth,
// 1 alpha depth) in the same cycle; write only while the block is idle.
// A pixel passes the front stage register, the queue, the packer's
// accumulator and the output register. Throughput: the packer emits one byte
// per cycle while the receiver takes them and loads the next pixel in the
// cycle that sends a pixel's last byte; this byte-wide packer sets the rate.
// The front quantizes one pixel per cycle into a small queue while it has room.
// Reset clears the leftover bits, the queue and the output register; depths
// return to 8 and 0. A stalled receiver holds the output byte, the packer and
// queue fill, and then in_ready_o drops; nothing is lost.
module texel_quantize_bit_packer_core #(
  parameter int unsigned FIFO_DEPTH = tqbp_pkg::FifoDepthDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  tqbp_pkg::pixel_t                in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output tqbp_pkg::byte_t                 out_data_o,
  input  logic                            cfg_we_i,
  input  logic [tqbp_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [tqbp_pkg::CfgDataW-1:0]   cfg_wdata_i
);
  import tqbp_pkg::*;

  cfg_t  cfg_q;
  logic  word_valid, word_ready;
  word_t word;
  logic  pk_valid, pk_ready;
  word_t pk_word;

  // configuration registers; unknown indexes are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.color_depth <= ColorDepthMax;
      cfg_q.alpha_depth <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgColorDepth: cfg_q.color_depth <= cfg_wdata_i[ColorDepthW-1:0];
        CfgAlphaDepth: cfg_q.alpha_depth <= cfg_wdata_i[AlphaDepthW-1:0];
        default: ;
      endcase
    end
  end

  tqbp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .cfg_i        (cfg_q),
    .word_valid_o (word_valid),
    .word_ready_i (word_ready),
    .word_o       (word)
  );

  tqbp_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (word_valid),
    .push_ready_o (word_ready),
    .push_data_i  (word),
    .pop_valid_o  (pk_valid),
    .pop_ready_i  (pk_ready),
    .pop_data_o   (pk_word)
  );

  tqbp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .word_valid_i (pk_valid),
    .word_ready_o (pk_ready),
    .word_i       (pk_word),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule
